### hw/rtl/edge_stop_trigger_debounce_core_defines.svh
// Assertion macros for the edge stop trigger debounce block
`ifndef EDGE_STOP_TRIGGER_DEBOUNCE_CORE_DEFINES_SVH
`define EDGE_STOP_TRIGGER_DEBOUNCE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ESDB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esdb assertion failed");

// next-cycle implication, checked out of reset
`define ESDB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esdb assertion failed");

`endif

### hw/rtl/esdb_pkg.sv
// Shared constants and types for the edge stop trigger debounce block
package esdb_pkg;

    localparam int CHANNEL_COUNT = 2;
    localparam int MASK_W        = 4;
    localparam int COUNT_W       = 16;
    localparam int DECEL_W       = 16;
    localparam int LED_MODE_W    = 2;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [DECEL_W-1:0] DECEL_RESET    = 16'hFFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;

    // action mask bit positions
    localparam int ACT_BRAKE_RISE = 0;
    localparam int ACT_STOP_RISE  = 1;
    localparam int ACT_BRAKE_FALL = 2;
    localparam int ACT_STOP_FALL  = 3;

    typedef enum logic [LED_MODE_W-1:0] {
        LED_ACTIVE_LOW  = 2'd0,
        LED_ACTIVE_HIGH = 2'd1,
        LED_UNTOUCHED   = 2'd2
    } led_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ACTION_MASK_A = 3'd0,
        REG_ACTION_MASK_B = 3'd1,
        REG_DEBOUNCE_MS_A = 3'd2,
        REG_DEBOUNCE_MS_B = 3'd3,
        REG_STOP_DECEL_A  = 3'd4,
        REG_STOP_DECEL_B  = 3'd5,
        REG_LED_MODE_A    = 3'd6,
        REG_LED_MODE_B    = 3'd7
    } cfg_reg_t;

endpackage

### hw/rtl/esdb_if.sv
// Handshake channel interfaces: sample input, result output, register write
interface esdb_sample_if;
    logic valid;
    logic ready;
    logic pin_level_a;
    logic pin_level_b;
    logic ms_tick;

    modport source (output valid, output pin_level_a, output pin_level_b, output ms_tick,
                    input ready);
    modport sink (input valid, input pin_level_a, input pin_level_b, input ms_tick,
                  output ready);
endinterface

interface esdb_result_if;
    logic                            valid;
    logic                            ready;
    logic                            full_brake_pulse;
    logic                            normal_stop_pulse;
    logic [esdb_pkg::DECEL_W-1:0]    decel_cmd;
    logic                            led_drive_a;
    logic                            led_drive_b;

    modport source (output valid, output full_brake_pulse, output normal_stop_pulse,
                    output decel_cmd, output led_drive_a, output led_drive_b,
                    input ready);
    modport sink (input valid, input full_brake_pulse, input normal_stop_pulse,
                  input decel_cmd, input led_drive_a, input led_drive_b,
                  output ready);
endinterface

interface esdb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [esdb_pkg::CFG_INDEX_W-1:0]  index;
    logic [esdb_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/edge_stop_trigger_debounce_core.sv
// Two-channel edge stop trigger with debounce lockout, top level
// A sample passes through the input register, then the result register, before result valid.
// Throughput: one sample per cycle while the result side does not stall; the single-pass edge
// and lockout logic between the input register and the result register sets this.
// Reset (rst_n, async, active low): configuration registers to their reset values, all
// channel state cleared, both pipeline stages empty.
`include "edge_stop_trigger_debounce_core_defines.svh"

module edge_stop_trigger_debounce_core (
    input  logic                  clk,
    input  logic                  rst_n,
    esdb_sample_if.sink           sample,
    esdb_result_if.source         result,
    esdb_cfg_if.sink              cfg
);

    localparam int CH = esdb_pkg::CHANNEL_COUNT;

    // configuration
    logic [esdb_pkg::MASK_W-1:0]     mask_reg     [CH];
    logic [esdb_pkg::COUNT_W-1:0]    debounce_reg [CH];
    logic [esdb_pkg::DECEL_W-1:0]    decel_reg    [CH];
    logic [esdb_pkg::LED_MODE_W-1:0] led_mode_reg [CH];

    // channel state
    logic [CH-1:0]                   prev_reg, prev_next;
    logic [CH-1:0]                   handled_reg, handled_next;
    logic [CH-1:0]                   lock_reg, lock_next;
    logic [CH-1:0]                   led_reg, led_next;
    logic [esdb_pkg::COUNT_W-1:0]    elapsed_reg  [CH];
    logic [esdb_pkg::COUNT_W-1:0]    elapsed_next [CH];
    logic [esdb_pkg::COUNT_W-1:0]    elapsed_inc  [CH];

    // pipeline
    logic                            in_valid_reg;
    logic [CH-1:0]                   pin_reg;
    logic                            tick_reg;
    logic                            out_valid_reg;
    logic                            brake_reg;
    logic                            stop_reg;
    logic [esdb_pkg::DECEL_W-1:0]    decel_out_reg;
    logic [CH-1:0]                   led_out_reg;

    logic                            advance;
    logic                            proc;
    logic [CH-1:0]                   edge_seen;
    logic [CH-1:0]                   handle;
    logic [CH-1:0]                   brake_ch;
    logic [CH-1:0]                   stop_ch;
    logic [esdb_pkg::DECEL_W-1:0]    decel_next;

    assign advance      = !out_valid_reg || result.ready;
    assign proc         = in_valid_reg && advance;
    assign sample.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            pin_reg  <= {sample.pin_level_b, sample.pin_level_a};
            tick_reg <= sample.ms_tick;
        end
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CH; c++)
            begin
                mask_reg[c]     <= '0;
                debounce_reg[c] <= esdb_pkg::DEBOUNCE_RESET;
                decel_reg[c]    <= esdb_pkg::DECEL_RESET;
                led_mode_reg[c] <= esdb_pkg::LED_ACTIVE_LOW;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (esdb_pkg::cfg_reg_t'(cfg.index))
                esdb_pkg::REG_ACTION_MASK_A: mask_reg[0] <= cfg.data[esdb_pkg::MASK_W-1:0];
                esdb_pkg::REG_ACTION_MASK_B: mask_reg[1] <= cfg.data[esdb_pkg::MASK_W-1:0];
                esdb_pkg::REG_DEBOUNCE_MS_A: debounce_reg[0] <= cfg.data;
                esdb_pkg::REG_DEBOUNCE_MS_B: debounce_reg[1] <= cfg.data;
                esdb_pkg::REG_STOP_DECEL_A:  decel_reg[0] <= cfg.data;
                esdb_pkg::REG_STOP_DECEL_B:  decel_reg[1] <= cfg.data;
                esdb_pkg::REG_LED_MODE_A:
                    led_mode_reg[0] <= cfg.data[esdb_pkg::LED_MODE_W-1:0];
                esdb_pkg::REG_LED_MODE_B:
                    led_mode_reg[1] <= cfg.data[esdb_pkg::LED_MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // edge handling and lockout, one pass per sample
    always_comb
    begin
        prev_next    = prev_reg;
        handled_next = handled_reg;
        lock_next    = lock_reg;
        led_next     = led_reg;
        edge_seen    = '0;
        handle       = '0;
        brake_ch     = '0;
        stop_ch      = '0;
        for (int c = 0; c < CH; c++)
        begin
            elapsed_next[c] = elapsed_reg[c];
            elapsed_inc[c]  = (elapsed_reg[c] != esdb_pkg::COUNT_MAX) ?
                              elapsed_reg[c] + esdb_pkg::COUNT_W'(1) : elapsed_reg[c];
            if (proc)
            begin
                edge_seen[c] = pin_reg[c] != prev_reg[c];
                handle[c]    = edge_seen[c] && !lock_reg[c] && (pin_reg[c] != handled_reg[c]);
                prev_next[c] = pin_reg[c];
                if (handle[c])
                begin
                    handled_next[c] = pin_reg[c];
                    if (debounce_reg[c] != '0)
                    begin
                        lock_next[c]    = 1'b1;
                        elapsed_next[c] = '0;
                    end
                    if (pin_reg[c])
                    begin
                        brake_ch[c] = mask_reg[c][esdb_pkg::ACT_BRAKE_RISE];
                        stop_ch[c]  = !mask_reg[c][esdb_pkg::ACT_BRAKE_RISE] &&
                                      mask_reg[c][esdb_pkg::ACT_STOP_RISE];
                    end
                    else
                    begin
                        brake_ch[c] = mask_reg[c][esdb_pkg::ACT_BRAKE_FALL];
                        stop_ch[c]  = !mask_reg[c][esdb_pkg::ACT_BRAKE_FALL] &&
                                      mask_reg[c][esdb_pkg::ACT_STOP_FALL];
                    end
                    case (led_mode_reg[c])
                        esdb_pkg::LED_ACTIVE_LOW:  led_next[c] = pin_reg[c];
                        esdb_pkg::LED_ACTIVE_HIGH: led_next[c] = !pin_reg[c];
                        default:                   led_next[c] = led_reg[c];
                    endcase
                end
                if (lock_reg[c] && tick_reg)
                begin
                    if (elapsed_inc[c] >= debounce_reg[c])
                    begin
                        lock_next[c]    = 1'b0;
                        elapsed_next[c] = '0;
                    end
                    else
                    begin
                        elapsed_next[c] = elapsed_inc[c];
                    end
                end
            end
        end
        // channel 1 wins a tie
        if (stop_ch[1])
        begin
            decel_next = decel_reg[1];
        end
        else if (stop_ch[0])
        begin
            decel_next = decel_reg[0];
        end
        else
        begin
            decel_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            handled_reg <= '0;
            lock_reg    <= '0;
            led_reg     <= '0;
            for (int c = 0; c < CH; c++)
            begin
                elapsed_reg[c] <= '0;
            end
        end
        else
        begin
            prev_reg    <= prev_next;
            handled_reg <= handled_next;
            lock_reg    <= lock_next;
            led_reg     <= led_next;
            for (int c = 0; c < CH; c++)
            begin
                elapsed_reg[c] <= elapsed_next[c];
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            brake_reg     <= |brake_ch;
            stop_reg      <= |stop_ch;
            decel_out_reg <= decel_next;
            led_out_reg   <= led_next;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.full_brake_pulse  = brake_reg;
    assign result.normal_stop_pulse = stop_reg;
    assign result.decel_cmd         = decel_out_reg;
    assign result.led_drive_a       = led_out_reg[0];
    assign result.led_drive_b       = led_out_reg[1];

    `ESDB_ASSERT_IMPL(a_idle_count_zero_a, !lock_reg[0], elapsed_reg[0] == '0)
    `ESDB_ASSERT_IMPL(a_idle_count_zero_b, !lock_reg[1], elapsed_reg[1] == '0)
    `ESDB_ASSERT_NEXT(a_locked_holds_level_a, lock_reg[0], handled_reg[0] == $past(handled_reg[0]))
    `ESDB_ASSERT_NEXT(a_locked_holds_level_b, lock_reg[1], handled_reg[1] == $past(handled_reg[1]))
    `ESDB_ASSERT_IMPL(a_no_stop_no_decel, out_valid_reg && !stop_reg, decel_out_reg == '0)

endmodule
